### rtl/sdseq_pkg.sv
// Package: shared types and constants for the SD card init and block sequencer.
`default_nettype none
package sdseq_pkg;

  // Sequencer phase
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CLK400 = 4'd1,
    PH_CMD0   = 4'd2,
    PH_CMD8   = 4'd3,
    PH_CMD55  = 4'd4,
    PH_ACMD41 = 4'd5,
    PH_CMD2   = 4'd6,
    PH_CMD3   = 4'd7,
    PH_CLK25  = 4'd8,
    PH_CMD7   = 4'd9,
    PH_CMD16  = 4'd10,
    PH_READY  = 4'd11,
    PH_XCMD   = 4'd12,
    PH_XDATA  = 4'd13
  } phase_t;

  // Input event kind
  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_COMPL = 2'd1,
    FN_REQ   = 2'd2,
    FN_DATA  = 2'd3
  } func_t;

  // Emitted action
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_CLOCK = 3'd1,
    ACT_CMD   = 3'd2,
    ACT_XFER  = 3'd3,
    ACT_DONE  = 3'd4,
    ACT_FAIL  = 3'd5
  } act_t;

  // Failure codes
  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_NOINIT  = 3'd1,
    ERR_CLOCK   = 3'd2,
    ERR_CMD     = 3'd3,
    ERR_TIMEOUT = 3'd4,
    ERR_DATA    = 3'd5
  } err_t;

  // Response kinds
  localparam logic [1:0] RSP_NONE = 2'd0;
  localparam logic [1:0] RSP_136  = 2'd1;
  localparam logic [1:0] RSP_48   = 2'd2;
  localparam logic [1:0] RSP_48B  = 2'd3;

  // Command indexes
  localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
  localparam logic [5:0] CMD_ALL_CID    = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA   = 6'd3;
  localparam logic [5:0] CMD_SELECT     = 6'd7;
  localparam logic [5:0] CMD_IF_COND    = 6'd8;
  localparam logic [5:0] CMD_BLOCKLEN   = 6'd16;
  localparam logic [5:0] CMD_READ_BLK   = 6'd17;
  localparam logic [5:0] CMD_WRITE_BLK  = 6'd24;
  localparam logic [5:0] CMD_OP_COND    = 6'd41;
  localparam logic [5:0] CMD_APP        = 6'd55;

  // Arguments and patterns
  localparam logic [31:0] ARG_IF_COND    = 32'h0000_01AA;
  localparam logic [7:0]  IF_ECHO        = 8'hAA;
  localparam logic [31:0] ARG_OCR_V2     = 32'h51FF_8000;
  localparam logic [31:0] ARG_OCR_V1     = 32'h00FF_8000;
  localparam logic [31:0] ARG_BLOCKLEN   = 32'd512;

  // Clocking
  localparam logic [29:0] BASE_DEFAULT   = 30'd100_000_000;
  localparam logic [9:0]  DIV_MAX        = 10'h3FF;

  // Result fields other than the action
  typedef struct packed {
    logic [15:0] card_address;
    logic        card_high_capacity;
    err_t        error_code;
    logic        data_read;
    logic        has_data;
    logic        check_enable;
    logic [1:0]  resp_kind;
    logic [31:0] cmd_arg;
    logic [5:0]  cmd_index;
    logic [9:0]  clock_divider;
  } result_t;

endpackage
`default_nettype wire

### rtl/sdseq_clk_div.sv
// SD clock divider computation for the 400 kHz and 25 MHz targets.
`default_nettype none
module sdseq_clk_div (
  input  wire logic [29:0] base_hz,
  output logic [9:0]       div_id,   // base / 800000, clamped 1..1023
  output logic [9:0]       div_op    // base / 50000000, clamped to at least 1
);

  logic [29:0] base_eff;
  logic [44:0] prod_id;
  logic [46:0] prod_op;
  logic [10:0] q_id;
  logic [4:0]  q_op;

  assign base_eff = (base_hz == 30'd0) ? sdseq_pkg::BASE_DEFAULT : base_hz;

  // 800000 = 2^8 * 3125: shift, then reciprocal multiply (exact for 22-bit values)
  assign prod_id = 45'(base_eff[29:8]) * 45'(23'd5497559);
  assign q_id    = prod_id[44:34];

  // 50000000 = 2^7 * 390625: shift, then reciprocal multiply (exact for 23-bit values)
  assign prod_op = 47'(base_eff[29:7]) * 47'(24'd11259000);
  assign q_op    = prod_op[46:42];

  // Clamp to the divider range
  always_comb begin
    if (q_id == 11'd0) begin
      div_id = 10'd1;
    end else if (q_id > 11'(sdseq_pkg::DIV_MAX)) begin
      div_id = sdseq_pkg::DIV_MAX;
    end else begin
      div_id = q_id[9:0];
    end
  end

  assign div_op = (q_op == 5'd0) ? 10'd1 : {5'd0, q_op};

endmodule
`default_nettype wire

### rtl/sd_card_init_and_block_sequencer.sv
// Top level: SD card initialization and single-block sequencer.
//
// Channel | Dir | Handshake             | Payload
// in_     | in  | in_tvalid/in_tready   | tuser: func; tdata: success..write_request
// out_    | out | out_tvalid/out_tready | tuser: action; tdata: divider..card_address
// cfg_    | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data (register write)
//
// Each event gives exactly one result, through the input register, then the
// result register. One event per cycle is sustained; both registers stall
// together when out_tready is low while the result register holds a result.
// rst_n is synchronous; it clears the handshake and card state, and sets the
// configuration to its defaults. cfg_ready is always high.
`default_nettype none
module sd_card_init_and_block_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // event input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  input  wire logic [71:0] in_tdata,   // [0] success, [32:1] response_word,
                                       // [64:33] block_lba, [65] write_request, rest 0
  // result output
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [2:0]       out_tuser,  // [2:0] action
  output logic [79:0]      out_tdata,  // [9:0] clock_divider, [15:10] cmd_index,
                                       // [47:16] cmd_arg, [49:48] resp_kind,
                                       // [50] check_enable, [51] has_data,
                                       // [52] data_read, [55:53] error_code,
                                       // [56] card_high_capacity,
                                       // [72:57] card_address, rest 0
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [29:0] cfg_data
);

  localparam logic CFG_BASE_CLOCK = 1'b0;
  localparam logic CFG_ATTEMPTS   = 1'b1;

  // configuration registers
  logic [29:0] base_hz_r;
  logic [9:0]  limit_r;

  // input stage
  logic             in_v_r;
  sdseq_pkg::func_t func_r;
  logic             ok_r;
  logic [31:0]      resp_r;
  logic [31:0]      lba_r;
  logic             wr_r;

  // sequencer state
  sdseq_pkg::phase_t phase_r, phase_nxt;
  logic        v2_r, v2_nxt;
  logic        hc_r, hc_nxt;
  logic [15:0] rca_r, rca_nxt;
  logic        init_r, init_nxt;
  logic [9:0]  att_r, att_nxt;
  logic        xwr_r, xwr_nxt;

  // result stage
  logic               out_v_r;
  sdseq_pkg::act_t    act_r, act_nxt;
  sdseq_pkg::result_t res_r, res_nxt;

  logic       advance;
  logic [9:0] div_id;
  logic [9:0] div_op;

  sdseq_clk_div u_clk_div (
    .base_hz (base_hz_r),
    .div_id  (div_id),
    .div_op  (div_op)
  );

  assign advance    = in_v_r && (!out_v_r || out_tready);
  assign in_tready  = !in_v_r || advance;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tuser  = act_r;
  assign out_tdata  = {7'd0, res_r};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_hz_r <= sdseq_pkg::BASE_DEFAULT;
      limit_r   <= 10'd500;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BASE_CLOCK: base_hz_r <= cfg_data;
        CFG_ATTEMPTS:   limit_r   <= cfg_data[9:0];
        default:        ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      func_r <= sdseq_pkg::func_t'(in_tuser);
      ok_r   <= in_tdata[0];
      resp_r <= in_tdata[32:1];
      lba_r  <= in_tdata[64:33];
      wr_r   <= in_tdata[65];
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    v2_nxt    = v2_r;
    hc_nxt    = hc_r;
    rca_nxt   = rca_r;
    init_nxt  = init_r;
    att_nxt   = att_r;
    xwr_nxt   = xwr_r;
    unique case (func_r)
      sdseq_pkg::FN_START: begin
        init_nxt  = 1'b0;
        v2_nxt    = 1'b0;
        hc_nxt    = 1'b0;
        rca_nxt   = 16'd0;
        att_nxt   = 10'd0;
        phase_nxt = sdseq_pkg::PH_CLK400;
      end
      sdseq_pkg::FN_COMPL: begin
        unique case (phase_r)
          sdseq_pkg::PH_CLK400:
            phase_nxt = ok_r ? sdseq_pkg::PH_CMD0 : sdseq_pkg::PH_IDLE;
          sdseq_pkg::PH_CMD0:
            phase_nxt = sdseq_pkg::PH_CMD8;
          sdseq_pkg::PH_CMD8: begin
            v2_nxt    = ok_r && (resp_r[7:0] == sdseq_pkg::IF_ECHO);
            att_nxt   = limit_r;
            phase_nxt = sdseq_pkg::PH_CMD55;
          end
          sdseq_pkg::PH_CMD55:
            phase_nxt = ok_r ? sdseq_pkg::PH_ACMD41 : sdseq_pkg::PH_IDLE;
          sdseq_pkg::PH_ACMD41: begin
            if (!ok_r) begin
              phase_nxt = sdseq_pkg::PH_IDLE;
            end else if (resp_r[31]) begin
              hc_nxt    = resp_r[30];
              phase_nxt = sdseq_pkg::PH_CMD2;
            end else if (att_r <= 10'd1) begin
              att_nxt   = 10'd0;
              phase_nxt = sdseq_pkg::PH_IDLE;
            end else begin
              att_nxt   = att_r - 10'd1;
              phase_nxt = sdseq_pkg::PH_CMD55;
            end
          end
          sdseq_pkg::PH_CMD2:
            phase_nxt = ok_r ? sdseq_pkg::PH_CMD3 : sdseq_pkg::PH_IDLE;
          sdseq_pkg::PH_CMD3: begin
            if (ok_r) begin
              rca_nxt   = resp_r[31:16];
              phase_nxt = sdseq_pkg::PH_CLK25;
            end else begin
              phase_nxt = sdseq_pkg::PH_IDLE;
            end
          end
          sdseq_pkg::PH_CLK25:
            phase_nxt = ok_r ? sdseq_pkg::PH_CMD7 : sdseq_pkg::PH_IDLE;
          sdseq_pkg::PH_CMD7:
            phase_nxt = ok_r ? sdseq_pkg::PH_CMD16 : sdseq_pkg::PH_IDLE;
          sdseq_pkg::PH_CMD16: begin
            if (ok_r) begin
              init_nxt  = 1'b1;
              phase_nxt = sdseq_pkg::PH_READY;
            end else begin
              phase_nxt = sdseq_pkg::PH_IDLE;
            end
          end
          sdseq_pkg::PH_XCMD:
            phase_nxt = ok_r ? sdseq_pkg::PH_XDATA : sdseq_pkg::PH_READY;
          default: ;
        endcase
      end
      sdseq_pkg::FN_REQ: begin
        if (init_r && phase_r == sdseq_pkg::PH_READY) begin
          xwr_nxt   = wr_r;
          phase_nxt = sdseq_pkg::PH_XCMD;
        end
      end
      sdseq_pkg::FN_DATA: begin
        if (phase_r == sdseq_pkg::PH_XDATA) begin
          phase_nxt = sdseq_pkg::PH_READY;
        end
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    act_nxt = sdseq_pkg::ACT_NONE;
    res_nxt = '0;
    unique case (func_r)
      sdseq_pkg::FN_START: begin
        act_nxt               = sdseq_pkg::ACT_CLOCK;
        res_nxt.clock_divider = div_id;
      end
      sdseq_pkg::FN_COMPL: begin
        unique case (phase_r)
          sdseq_pkg::PH_CLK400: begin
            if (ok_r) begin
              act_nxt           = sdseq_pkg::ACT_CMD;
              res_nxt.cmd_index = sdseq_pkg::CMD_GO_IDLE;
              res_nxt.resp_kind = sdseq_pkg::RSP_NONE;
            end else begin
              act_nxt            = sdseq_pkg::ACT_FAIL;
              res_nxt.error_code = sdseq_pkg::ERR_CLOCK;
            end
          end
          sdseq_pkg::PH_CMD0: begin
            act_nxt              = sdseq_pkg::ACT_CMD;
            res_nxt.cmd_index    = sdseq_pkg::CMD_IF_COND;
            res_nxt.cmd_arg      = sdseq_pkg::ARG_IF_COND;
            res_nxt.resp_kind    = sdseq_pkg::RSP_48;
            res_nxt.check_enable = 1'b1;
          end
          sdseq_pkg::PH_CMD8: begin
            act_nxt              = sdseq_pkg::ACT_CMD;
            res_nxt.cmd_index    = sdseq_pkg::CMD_APP;
            res_nxt.cmd_arg      = {rca_r, 16'd0};
            res_nxt.resp_kind    = sdseq_pkg::RSP_48;
            res_nxt.check_enable = 1'b1;
          end
          sdseq_pkg::PH_CMD55: begin
            if (ok_r) begin
              act_nxt           = sdseq_pkg::ACT_CMD;
              res_nxt.cmd_index = sdseq_pkg::CMD_OP_COND;
              res_nxt.cmd_arg   = v2_r ? sdseq_pkg::ARG_OCR_V2 : sdseq_pkg::ARG_OCR_V1;
              res_nxt.resp_kind = sdseq_pkg::RSP_48;
            end else begin
              act_nxt            = sdseq_pkg::ACT_FAIL;
              res_nxt.error_code = sdseq_pkg::ERR_CMD;
            end
          end
          sdseq_pkg::PH_ACMD41: begin
            if (!ok_r) begin
              act_nxt            = sdseq_pkg::ACT_FAIL;
              res_nxt.error_code = sdseq_pkg::ERR_CMD;
            end else if (resp_r[31]) begin
              act_nxt           = sdseq_pkg::ACT_CMD;
              res_nxt.cmd_index = sdseq_pkg::CMD_ALL_CID;
              res_nxt.resp_kind = sdseq_pkg::RSP_136;
            end else if (att_r <= 10'd1) begin
              act_nxt            = sdseq_pkg::ACT_FAIL;
              res_nxt.error_code = sdseq_pkg::ERR_TIMEOUT;
            end else begin
              act_nxt              = sdseq_pkg::ACT_CMD;
              res_nxt.cmd_index    = sdseq_pkg::CMD_APP;
              res_nxt.cmd_arg      = {rca_r, 16'd0};
              res_nxt.resp_kind    = sdseq_pkg::RSP_48;
              res_nxt.check_enable = 1'b1;
            end
          end
          sdseq_pkg::PH_CMD2: begin
            if (ok_r) begin
              act_nxt              = sdseq_pkg::ACT_CMD;
              res_nxt.cmd_index    = sdseq_pkg::CMD_SEND_RCA;
              res_nxt.resp_kind    = sdseq_pkg::RSP_48;
              res_nxt.check_enable = 1'b1;
            end else begin
              act_nxt            = sdseq_pkg::ACT_FAIL;
              res_nxt.error_code = sdseq_pkg::ERR_CMD;
            end
          end
          sdseq_pkg::PH_CMD3: begin
            if (ok_r) begin
              act_nxt               = sdseq_pkg::ACT_CLOCK;
              res_nxt.clock_divider = div_op;
            end else begin
              act_nxt            = sdseq_pkg::ACT_FAIL;
              res_nxt.error_code = sdseq_pkg::ERR_CMD;
            end
          end
          sdseq_pkg::PH_CLK25: begin
            if (ok_r) begin
              act_nxt              = sdseq_pkg::ACT_CMD;
              res_nxt.cmd_index    = sdseq_pkg::CMD_SELECT;
              res_nxt.cmd_arg      = {rca_r, 16'd0};
              res_nxt.resp_kind    = sdseq_pkg::RSP_48B;
              res_nxt.check_enable = 1'b1;
            end else begin
              act_nxt            = sdseq_pkg::ACT_FAIL;
              res_nxt.error_code = sdseq_pkg::ERR_CLOCK;
            end
          end
          sdseq_pkg::PH_CMD7: begin
            if (ok_r) begin
              act_nxt              = sdseq_pkg::ACT_CMD;
              res_nxt.cmd_index    = sdseq_pkg::CMD_BLOCKLEN;
              res_nxt.cmd_arg      = sdseq_pkg::ARG_BLOCKLEN;
              res_nxt.resp_kind    = sdseq_pkg::RSP_48;
              res_nxt.check_enable = 1'b1;
            end else begin
              act_nxt            = sdseq_pkg::ACT_FAIL;
              res_nxt.error_code = sdseq_pkg::ERR_CMD;
            end
          end
          sdseq_pkg::PH_CMD16: begin
            if (ok_r) begin
              act_nxt = sdseq_pkg::ACT_DONE;
            end else begin
              act_nxt            = sdseq_pkg::ACT_FAIL;
              res_nxt.error_code = sdseq_pkg::ERR_CMD;
            end
          end
          sdseq_pkg::PH_XCMD: begin
            if (!ok_r) begin
              act_nxt            = sdseq_pkg::ACT_FAIL;
              res_nxt.error_code = sdseq_pkg::ERR_CMD;
            end
          end
          default: ;
        endcase
      end
      sdseq_pkg::FN_REQ: begin
        if (!init_r) begin
          act_nxt            = sdseq_pkg::ACT_FAIL;
          res_nxt.error_code = sdseq_pkg::ERR_NOINIT;
        end else if (phase_r == sdseq_pkg::PH_READY) begin
          // block addressing on high capacity, byte addressing otherwise
          act_nxt              = sdseq_pkg::ACT_XFER;
          res_nxt.cmd_index    = wr_r ? sdseq_pkg::CMD_WRITE_BLK : sdseq_pkg::CMD_READ_BLK;
          res_nxt.cmd_arg      = hc_r ? lba_r : {lba_r[22:0], 9'd0};
          res_nxt.resp_kind    = sdseq_pkg::RSP_48;
          res_nxt.check_enable = 1'b1;
          res_nxt.has_data     = 1'b1;
          res_nxt.data_read    = !wr_r;
        end
      end
      sdseq_pkg::FN_DATA: begin
        if (phase_r == sdseq_pkg::PH_XDATA) begin
          if (ok_r) begin
            act_nxt = sdseq_pkg::ACT_DONE;
          end else begin
            act_nxt            = sdseq_pkg::ACT_FAIL;
            res_nxt.error_code = sdseq_pkg::ERR_DATA;
          end
        end
      end
      default: ;
    endcase
    res_nxt.card_high_capacity = hc_nxt;
    res_nxt.card_address       = rca_nxt;
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sdseq_pkg::PH_IDLE;
      v2_r    <= 1'b0;
      hc_r    <= 1'b0;
      rca_r   <= 16'd0;
      init_r  <= 1'b0;
      att_r   <= 10'd0;
      xwr_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (advance) begin
        phase_r <= phase_nxt;
        v2_r    <= v2_nxt;
        hc_r    <= hc_nxt;
        rca_r   <= rca_nxt;
        init_r  <= init_nxt;
        att_r   <= att_nxt;
        xwr_r   <= xwr_nxt;
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      act_r <= act_nxt;
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

### tb/tb_sd_card_init_and_block_sequencer.sv
// Testbench for the SD card init and block sequencer: scripted and random event streams.
`timescale 1ns / 100ps
module tb_sd_card_init_and_block_sequencer;
  import sdseq_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 9;
  localparam int PIPE_LATENCY = 2;
  localparam int TIMEOUT_CYCLES = 400_000;
  localparam int ITEMS_PER_PACE = 475;
  localparam int unsigned ID_CLOCK_HZ = 400_000;
  localparam int unsigned XFER_CLOCK_HZ = 25_000_000;
  localparam logic [9:0] ATTEMPT_LIMIT_DEFAULT = 10'd500;
  localparam logic REG_BASE_CLOCK = 1'b0;
  localparam logic REG_ATTEMPT_LIMIT = 1'b1;

  // One predicted result: action plus the packed result fields
  typedef struct {
    act_t    action;
    result_t f;
  } seq_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [2:0]  out_tuser;
  logic [79:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [29:0] cfg_data = '0;

  // Pacing knobs
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_off_cycles = 0;

  // Predictor state and configuration
  logic [29:0] base_clock = BASE_DEFAULT;
  logic [9:0]  attempt_limit = ATTEMPT_LIMIT_DEFAULT;
  phase_t      seq_phase = PH_IDLE;
  logic        v2_card = 1'b0;
  logic        hc_card = 1'b0;
  logic [15:0] rca = '0;
  logic        card_ready = 1'b0;
  logic [9:0]  tries_left = '0;
  logic        xfer_write = 1'b0;

  seq_result_t pending_results[$];

  // Run statistics
  int error_count = 0;
  int results_checked = 0;
  int items_sent = 0;
  int acting_items = 0;
  int sessions_run = 0;
  int inits_done = 0;
  int transfers_issued = 0;
  int failures_predicted = 0;
  int config_writes = 0;

  sd_card_init_and_block_sequencer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [9:0] clock_divider_for(input int unsigned sd_clk_hz);
    int unsigned base_hz;
    int unsigned quotient;
    base_hz = (base_clock == '0) ? 32'(BASE_DEFAULT) : 32'(base_clock);
    quotient = base_hz / (sd_clk_hz * 2);
    if (quotient == 0) quotient = 1;
    if (quotient > 32'(DIV_MAX)) quotient = 32'(DIV_MAX);
    return quotient[9:0];
  endfunction

  function automatic result_t command_word(input logic [5:0] idx, input logic [31:0] arg,
                                           input logic [1:0] kind, input logic chk,
                                           input logic dat, input logic rd);
    result_t r;
    r = '0;
    r.cmd_index = idx;
    r.cmd_arg = arg;
    r.resp_kind = kind;
    r.check_enable = chk;
    r.has_data = dat;
    r.data_read = rd;
    return r;
  endfunction

  // Works out the result of one accepted event and advances the card state
  task automatic predict_event(input func_t fn, input logic ok, input logic [31:0] resp,
                               input logic [31:0] lba, input logic wr);
    seq_result_t e;
    e.action = ACT_NONE;
    e.f = '0;
    items_sent++;
    case (fn)
      FN_START: begin
        card_ready = 1'b0;
        v2_card = 1'b0;
        hc_card = 1'b0;
        rca = '0;
        tries_left = '0;
        e.action = ACT_CLOCK;
        e.f.clock_divider = clock_divider_for(ID_CLOCK_HZ);
        seq_phase = PH_CLK400;
      end
      FN_COMPL: begin
        case (seq_phase)
          PH_CLK400: begin
            if (!ok) begin
              e.action = ACT_FAIL; e.f.error_code = ERR_CLOCK; seq_phase = PH_IDLE;
            end else begin
              e.action = ACT_CMD;
              e.f = command_word(CMD_GO_IDLE, '0, RSP_NONE, 1'b0, 1'b0, 1'b0);
              seq_phase = PH_CMD0;
            end
          end
          // CMD0 outcome is never checked
          PH_CMD0: begin
            e.action = ACT_CMD;
            e.f = command_word(CMD_IF_COND, ARG_IF_COND, RSP_48, 1'b1, 1'b0, 1'b0);
            seq_phase = PH_CMD8;
          end
          // a failed CMD8 only marks a version 1 card
          PH_CMD8: begin
            v2_card = ok && (resp[7:0] == IF_ECHO);
            tries_left = attempt_limit;
            e.action = ACT_CMD;
            e.f = command_word(CMD_APP, {rca, 16'h0}, RSP_48, 1'b1, 1'b0, 1'b0);
            seq_phase = PH_CMD55;
          end
          PH_CMD55: begin
            if (!ok) begin
              e.action = ACT_FAIL; e.f.error_code = ERR_CMD; seq_phase = PH_IDLE;
            end else begin
              e.action = ACT_CMD;
              e.f = command_word(CMD_OP_COND, v2_card ? ARG_OCR_V2 : ARG_OCR_V1, RSP_48,
                                 1'b0, 1'b0, 1'b0);
              seq_phase = PH_ACMD41;
            end
          end
          PH_ACMD41: begin
            if (!ok) begin
              e.action = ACT_FAIL; e.f.error_code = ERR_CMD; seq_phase = PH_IDLE;
            end else if (resp[31]) begin
              hc_card = resp[30];
              e.action = ACT_CMD;
              e.f = command_word(CMD_ALL_CID, '0, RSP_136, 1'b0, 1'b0, 1'b0);
              seq_phase = PH_CMD2;
            end else if (tries_left <= 10'd1) begin
              // a zero limit acts as one try
              tries_left = '0;
              e.action = ACT_FAIL; e.f.error_code = ERR_TIMEOUT; seq_phase = PH_IDLE;
            end else begin
              tries_left = tries_left - 10'd1;
              e.action = ACT_CMD;
              e.f = command_word(CMD_APP, {rca, 16'h0}, RSP_48, 1'b1, 1'b0, 1'b0);
              seq_phase = PH_CMD55;
            end
          end
          PH_CMD2: begin
            if (!ok) begin
              e.action = ACT_FAIL; e.f.error_code = ERR_CMD; seq_phase = PH_IDLE;
            end else begin
              e.action = ACT_CMD;
              e.f = command_word(CMD_SEND_RCA, '0, RSP_48, 1'b1, 1'b0, 1'b0);
              seq_phase = PH_CMD3;
            end
          end
          PH_CMD3: begin
            if (!ok) begin
              e.action = ACT_FAIL; e.f.error_code = ERR_CMD; seq_phase = PH_IDLE;
            end else begin
              rca = resp[31:16];
              e.action = ACT_CLOCK;
              e.f.clock_divider = clock_divider_for(XFER_CLOCK_HZ);
              seq_phase = PH_CLK25;
            end
          end
          PH_CLK25: begin
            if (!ok) begin
              e.action = ACT_FAIL; e.f.error_code = ERR_CLOCK; seq_phase = PH_IDLE;
            end else begin
              e.action = ACT_CMD;
              e.f = command_word(CMD_SELECT, {rca, 16'h0}, RSP_48B, 1'b1, 1'b0, 1'b0);
              seq_phase = PH_CMD7;
            end
          end
          PH_CMD7: begin
            if (!ok) begin
              e.action = ACT_FAIL; e.f.error_code = ERR_CMD; seq_phase = PH_IDLE;
            end else begin
              e.action = ACT_CMD;
              e.f = command_word(CMD_BLOCKLEN, ARG_BLOCKLEN, RSP_48, 1'b1, 1'b0, 1'b0);
              seq_phase = PH_CMD16;
            end
          end
          PH_CMD16: begin
            if (!ok) begin
              e.action = ACT_FAIL; e.f.error_code = ERR_CMD; seq_phase = PH_IDLE;
            end else begin
              card_ready = 1'b1;
              e.action = ACT_DONE;
              seq_phase = PH_READY;
              inits_done++;
            end
          end
          PH_XCMD: begin
            if (!ok) begin
              e.action = ACT_FAIL; e.f.error_code = ERR_CMD; seq_phase = PH_READY;
            end else begin
              seq_phase = PH_XDATA;
            end
          end
          default: ;  // stray completion
        endcase
      end
      FN_REQ: begin
        if (!card_ready) begin
          e.action = ACT_FAIL;
          e.f.error_code = ERR_NOINIT;
        end else if (seq_phase == PH_READY) begin
          xfer_write = wr;
          e.action = ACT_XFER;
          e.f = command_word(wr ? CMD_WRITE_BLK : CMD_READ_BLK,
                             hc_card ? lba : {lba[22:0], 9'h0}, RSP_48, 1'b1, 1'b1, !wr);
          seq_phase = PH_XCMD;
          transfers_issued++;
        end
      end
      default: begin
        if (seq_phase == PH_XDATA) begin
          seq_phase = PH_READY;
          if (ok) begin
            e.action = ACT_DONE;
          end else begin
            e.action = ACT_FAIL;
            e.f.error_code = ERR_DATA;
          end
        end
      end
    endcase
    e.f.card_high_capacity = hc_card;
    e.f.card_address = rca;
    if (e.action != ACT_NONE) acting_items++;
    if (e.action == ACT_FAIL) failures_predicted++;
    pending_results.push_back(e);
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic send_event(input func_t fn, input logic ok, input logic [31:0] resp,
                            input logic [31:0] lba, input logic wr);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= {6'b0, wr, lba, resp, ok};
    do @(posedge clk); while (!in_tready);
    predict_event(fn, ok, resp, lba, wr);
  endtask

  // Lowers the input and waits until every predicted result has been seen
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [29:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_BASE_CLOCK) base_clock = value;
    else attempt_limit = value[9:0];
    config_writes++;
  endtask

  // Output side: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      out_tready <= 1'b0;
      hold_off_cycles--;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  seq_result_t want_result;
  result_t     seen_fields;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $error("result with no event waiting: action %0d", out_tuser);
        error_count++;
      end else begin
        want_result = pending_results.pop_front();
        seen_fields = out_tdata[72:0];
        check_field("action", 32'(want_result.action), 32'(out_tuser));
        check_field("clock_divider", 32'(want_result.f.clock_divider),
                    32'(seen_fields.clock_divider));
        check_field("cmd_index", 32'(want_result.f.cmd_index), 32'(seen_fields.cmd_index));
        check_field("cmd_arg", want_result.f.cmd_arg, seen_fields.cmd_arg);
        check_field("resp_kind", 32'(want_result.f.resp_kind), 32'(seen_fields.resp_kind));
        check_field("check_enable", 32'(want_result.f.check_enable),
                    32'(seen_fields.check_enable));
        check_field("has_data", 32'(want_result.f.has_data), 32'(seen_fields.has_data));
        check_field("data_read", 32'(want_result.f.data_read), 32'(seen_fields.data_read));
        check_field("error_code", 32'(want_result.f.error_code),
                    32'(seen_fields.error_code));
        check_field("card_high_capacity", 32'(want_result.f.card_high_capacity),
                    32'(seen_fields.card_high_capacity));
        check_field("card_address", 32'(want_result.f.card_address),
                    32'(seen_fields.card_address));
        check_field("tdata_pad", 32'd0, 32'(out_tdata[79:73]));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [31:0] random_lba();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_noise(input bit allow_start);
    func_t fn;
    fn = func_t'($urandom_range(3, allow_start ? 0 : 1));
    send_event(fn, 1'($urandom_range(1)), $urandom, random_lba(), 1'($urandom_range(1)));
  endtask

  // Completion for the command pending in the init sequence, mostly a good card
  task automatic send_init_completion();
    logic        ok;
    logic [31:0] resp;
    ok = ($urandom_range(99) < 96);
    resp = $urandom;
    case (seq_phase)
      PH_CMD0: ok = 1'($urandom_range(1));
      PH_CMD8: begin
        ok = ($urandom_range(99) < 75);
        if ($urandom_range(99) < 70) resp[7:0] = IF_ECHO;
      end
      PH_ACMD41: resp[31] = ($urandom_range(99) < 30);
      default: ;
    endcase
    send_event(FN_COMPL, ok, resp, $urandom, 1'($urandom_range(1)));
  endtask

  // One init attempt followed, if it succeeds, by a run of block transfers
  task automatic random_session();
    int n_xfers;
    sessions_run++;
    send_event(FN_START, 1'($urandom_range(1)), $urandom, $urandom, 1'($urandom_range(1)));
    while (seq_phase != PH_IDLE && seq_phase < PH_READY) begin
      if ($urandom_range(99) < 6) send_noise(1'b1);
      else send_init_completion();
    end
    n_xfers = $urandom_range(12, 2);
    repeat (n_xfers) begin
      if (seq_phase != PH_READY) break;
      if ($urandom_range(99) < 8) send_noise(1'b0);
      send_event(FN_REQ, 1'($urandom_range(1)), $urandom, random_lba(),
                 1'($urandom_range(1)));
      if (seq_phase == PH_XCMD) begin
        if ($urandom_range(99) < 8) send_noise(1'b0);
        send_event(FN_COMPL, $urandom_range(99) < 92, $urandom, $urandom,
                   1'($urandom_range(1)));
      end
      if (seq_phase == PH_XDATA) begin
        if ($urandom_range(99) < 8) send_noise(1'b0);
        send_event(FN_DATA, $urandom_range(99) < 90, $urandom, $urandom,
                   1'($urandom_range(1)));
      end
    end
  endtask

  task automatic write_random_config();
    logic [29:0] base_hz;
    logic [9:0]  limit;
    case ($urandom_range(5))
      0: base_hz = '0;
      1: base_hz = 30'd1;
      2: base_hz = '1;
      3: base_hz = BASE_DEFAULT;
      4: base_hz = 30'($urandom_range(60_000_000, 800_000));
      default: base_hz = 30'($urandom);
    endcase
    case ($urandom_range(5))
      0: limit = '0;
      1: limit = 10'd1;
      2: limit = 10'h3FF;
      3: limit = 10'($urandom_range(4, 2));
      default: limit = 10'($urandom_range(20, 1));
    endcase
    write_register(REG_BASE_CLOCK, base_hz);
    write_register(REG_ATTEMPT_LIMIT, {20'($urandom), limit});
  endtask

  // ---------------------------------------------------------------- tests

  // Events before any init: request fails, data event is ignored
  task automatic test_before_init();
    send_event(FN_REQ, 1'b1, '1, '1, 1'b1);
    send_event(FN_DATA, 1'b1, '0, '0, 1'b0);
  endtask

  // Output held off while events keep coming, then a full drain
  task automatic test_output_backpressure();
    hold_off_cycles = 48;
    repeat (12) send_event(1'($urandom_range(1)) ? FN_REQ : FN_DATA, 1'($urandom_range(1)),
                           $urandom, $urandom, 1'($urandom_range(1)));
    wait_for_results();
  endtask

  // Version 2 high-capacity card with one power-up retry, default clocking
  task automatic test_init_high_capacity();
    send_event(FN_START, 1'b1, '1, '1, 1'b1);
    send_event(FN_COMPL, 1'b1, '0, '0, 1'b0);
    send_event(FN_COMPL, 1'b0, '0, '0, 1'b0);            // CMD0 failure ignored
    send_event(FN_COMPL, 1'b1, ARG_IF_COND, '0, 1'b0);
    send_event(FN_COMPL, 1'b1, '0, '0, 1'b0);
    send_event(FN_COMPL, 1'b1, ARG_OCR_V1, '0, 1'b0);    // still powering up
    send_event(FN_COMPL, 1'b1, '0, '0, 1'b0);
    send_event(FN_COMPL, 1'b1, 32'hC0FF_8000, '0, 1'b0);
    send_event(FN_COMPL, 1'b1, $urandom, '0, 1'b0);
    send_event(FN_COMPL, 1'b1, 32'hFFFF_0000, '0, 1'b0); // widest RCA
    send_event(FN_COMPL, 1'b1, '0, '0, 1'b0);
    send_event(FN_COMPL, 1'b1, '0, '0, 1'b0);
    send_event(FN_COMPL, 1'b1, '0, '0, 1'b0);
  endtask

  // Reads and writes, including overlap, command failure and data failure
  task automatic test_block_transfers();
    send_event(FN_REQ, 1'b0, '0, '1, 1'b0);
    send_event(FN_REQ, 1'b1, '0, 32'h1234_5678, 1'b1);   // ignored, transfer pending
    send_event(FN_DATA, 1'b1, '0, '0, 1'b0);             // stray, command not done
    send_event(FN_COMPL, 1'b1, '1, '0, 1'b0);
    send_event(FN_DATA, 1'b1, '0, '0, 1'b0);
    send_event(FN_REQ, 1'b1, '0, '0, 1'b1);
    send_event(FN_COMPL, 1'b0, '0, '0, 1'b0);
    send_event(FN_REQ, 1'b1, '0, 32'd1, 1'b1);
    send_event(FN_COMPL, 1'b1, '0, '0, 1'b0);
    send_event(FN_DATA, 1'b0, '1, '1, 1'b1);
  endtask

  // Restart in mid-init, version 1 card, zero attempt limit times out at once
  task automatic test_zero_attempt_limit();
    wait_for_results();
    write_register(REG_BASE_CLOCK, 30'd1);
    write_register(REG_ATTEMPT_LIMIT, 30'h3FFF_FC00);
    send_event(FN_START, 1'b0, '0, '0, 1'b0);
    send_event(FN_COMPL, 1'b1, '0, '0, 1'b0);
    send_event(FN_START, 1'b0, '0, '0, 1'b0);
    send_event(FN_COMPL, 1'b1, '0, '0, 1'b0);
    send_event(FN_COMPL, 1'b1, '0, '0, 1'b0);
    send_event(FN_COMPL, 1'b0, ARG_IF_COND, '0, 1'b0);
    send_event(FN_COMPL, 1'b1, '0, '0, 1'b0);
    send_event(FN_COMPL, 1'b1, '0, '0, 1'b0);
    send_event(FN_REQ, 1'b1, '0, '0, 1'b0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [29:0] base_hz, input logic [9:0] limit);
    int stop_at;
    wait_for_results();
    write_register(REG_BASE_CLOCK, base_hz);
    write_register(REG_ATTEMPT_LIMIT, {20'($urandom), limit});
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    stop_at = items_sent + ITEMS_PER_PACE;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        wait_for_results();
        write_random_config();
      end
      random_session();
    end
  endtask

  // ---------------------------------------------------------------- main sequence

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_init();
    test_output_backpressure();
    test_init_high_capacity();
    test_block_transfers();
    test_zero_attempt_limit();
    test_random_traffic(0, 0, BASE_DEFAULT, ATTEMPT_LIMIT_DEFAULT);
    test_random_traffic(71, 0, '0, 10'h3FF);
    test_random_traffic(0, 71, '1, 10'd1);
    test_random_traffic(7, 7, 30'd1, 10'd3);

    wait_for_results();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    $display("Sent %0d events over %0d init sessions (%0d reached ready), %0d block transfers,",
             items_sent, sessions_run, inits_done, transfers_issued);
    $display("%0d failures predicted, %0d register writes, %0d results compared.",
             failures_predicted, config_writes, results_checked);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/sdseq_pkg.sv
rtl/sdseq_clk_div.sv
rtl/sd_card_init_and_block_sequencer.sv
tb/tb_sd_card_init_and_block_sequencer.sv
